@@ rtl/srq_pkg.sv @@
// Shared types and constants of the selective-repeat ARQ endpoint.
// No dependencies; imported by every module of the block.
`default_nettype none

package srq_pkg;

    localparam int TIMER_W     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0]         MY_ADDR_RESET = 8'd0;
    localparam logic [7:0]         WINDOW_RESET  = 8'd8;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] CFG_MY_ADDR = 2'd0;
    localparam logic [1:0] CFG_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        FN_SEND = 3'd0,
        FN_ACK  = 3'd1,
        FN_NAK  = 3'd2,
        FN_TICK = 3'd3,
        FN_DATA = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_NEW  = 2'd0,
        KIND_RETX = 2'd1,
        KIND_ACK  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [7:0]         my_address;
        logic [7:0]         window_size;
        logic [TIMER_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] seq;
        logic [7:0] dest;
        logic       last;
    } srq_result_t;

endpackage

`default_nettype wire

@@ rtl/srq_engine.sv @@
// Protocol engine: sequencer, slot memory (sequence, destination, timer),
// slot valid bits and one-deep result lookahead. Depends on srq_pkg.
`default_nettype none

module srq_engine
    import srq_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int SEQ_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [7:0]  seq_number,
    input  wire logic [7:0]  dest_address,
    input  wire logic [7:0]  src_address,
    input  wire cfg_t        cfg,
    output logic             push_valid,
    output srq_result_t      push_data,
    input  wire logic        out_free
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = (SEQ_BITS > 8) ? SEQ_BITS : 8;
    localparam int RECIP = (65536 + SLOTS - 1) / SLOTS;

    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        logic [7:0]          dest;
        logic [TIMER_W-1:0]  timer;
    } slot_word_t;

    // exact for every 8-bit s: quotient by reciprocal, remainder by subtract
    function automatic logic [IDX_W-1:0] slot_of(input logic [7:0] s);
        logic [23:0] prod;
        logic [7:0]  q;
        logic [15:0] r;
        prod = 24'(s) * 24'(RECIP);
        q    = prod[23:16];
        r    = 16'(s) - 16'(q) * 16'(SLOTS);
        return IDX_W'(r);
    endfunction

    state_t              state_reg, state_next;
    func_t               item_func_reg;
    logic [SEQ_BITS-1:0] item_seq_reg;
    logic [7:0]          item_dest_reg;
    logic [7:0]          item_src_reg;
    logic [SEQ_BITS-1:0] next_seq_reg, next_seq_next;
    logic [IDX_W-1:0]    next_slot_reg, next_slot_next;
    logic [SEQ_BITS-1:0] last_acked_reg, last_acked_next;
    logic [SLOTS-1:0]    slot_valid_reg, slot_valid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                pend_valid_reg, pend_valid_next;
    srq_result_t         pend_reg, pend_next;

    slot_word_t          slot_mem [SLOTS];
    slot_word_t          rd_data_reg;
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    slot_word_t          mem_wr_data;
    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;

    logic                emit;
    srq_result_t         emit_data;
    logic                scan_emit;
    logic                scan_hold;
    logic [TIMER_W-1:0]  wr_timer;
    logic [SEQ_BITS-1:0] d_win;
    logic [SEQ_BITS-1:0] d_ack;
    logic                win_ok;
    logic                ack_adv;
    logic                match;
    logic [IDX_W-1:0]    seq_slot;

    assign d_win    = next_seq_reg - last_acked_reg;
    assign win_ok   = CMP_W'(d_win) < CMP_W'(cfg.window_size);
    assign d_ack    = item_seq_reg - last_acked_reg;
    assign ack_adv  = (d_ack != '0) && !d_ack[SEQ_BITS-1];
    assign seq_slot = slot_of(8'(item_seq_reg));
    assign match    = slot_valid_reg[idx_reg] && (rd_data_reg.seq == item_seq_reg);

    always_comb
    begin
        state_next      = state_reg;
        next_seq_next   = next_seq_reg;
        next_slot_next  = next_slot_reg;
        last_acked_next = last_acked_reg;
        slot_valid_next = slot_valid_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = rd_data_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_reg;
        emit            = 1'b0;
        emit_data       = '{kind: KIND_NEW, seq: '0, dest: '0, last: 1'b0};
        scan_emit       = 1'b0;
        scan_hold       = 1'b0;
        wr_timer        = '0;
        push_valid      = 1'b0;
        push_data       = pend_reg;
        in_stall        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FLUSH;
                unique case (item_func_reg) inside
                    FN_SEND:
                    begin
                        if (win_ok)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = next_slot_reg;
                            mem_wr_data = '{seq: next_seq_reg, dest: item_dest_reg,
                                            timer: cfg.timeout_ticks};
                            slot_valid_next[next_slot_reg] = 1'b1;
                            emit      = 1'b1;
                            emit_data = '{kind: KIND_NEW, seq: 8'(next_seq_reg),
                                          dest: item_dest_reg, last: 1'b0};
                            next_seq_next = next_seq_reg + 1'b1;
                            if ((next_seq_reg == '1) || (next_slot_reg == IDX_W'(SLOTS - 1)))
                            begin
                                next_slot_next = '0;
                            end
                            else
                            begin
                                next_slot_next = next_slot_reg + 1'b1;
                            end
                        end
                    end
                    FN_ACK, FN_NAK:
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = seq_slot;
                        idx_next    = seq_slot;
                        state_next  = ST_LOOKUP;
                    end
                    FN_TICK:
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        idx_next    = '0;
                        n_next      = '0;
                        state_next  = ST_SCAN;
                    end
                    FN_DATA:
                    begin
                        if (item_dest_reg == cfg.my_address)
                        begin
                            emit      = 1'b1;
                            emit_data = '{kind: KIND_ACK, seq: 8'(item_seq_reg),
                                          dest: item_src_reg, last: 1'b0};
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LOOKUP:
            begin
                state_next = ST_FLUSH;
                if (item_func_reg == FN_ACK)
                begin
                    if (match)
                    begin
                        slot_valid_next[idx_reg] = 1'b0;
                    end
                    if (ack_adv)
                    begin
                        last_acked_next = item_seq_reg;
                    end
                end
                else if (match)
                begin
                    emit      = 1'b1;
                    emit_data = '{kind: KIND_RETX, seq: 8'(rd_data_reg.seq),
                                  dest: rd_data_reg.dest, last: 1'b0};
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = idx_reg;
                    mem_wr_data = '{seq: rd_data_reg.seq, dest: rd_data_reg.dest,
                                    timer: cfg.timeout_ticks};
                end
            end
            ST_SCAN:
            begin
                if (slot_valid_reg[idx_reg])
                begin
                    if (rd_data_reg.timer > TIMER_W'(1))
                    begin
                        wr_timer = rd_data_reg.timer - 1'b1;
                    end
                    else if (n_reg < CNT_W'(MAX_RESULTS))
                    begin
                        scan_emit = 1'b1;
                        wr_timer  = cfg.timeout_ticks;
                    end
                end
                scan_hold = scan_emit && pend_valid_reg && !out_free;
                if (!scan_hold)
                begin
                    mem_wr_en   = slot_valid_reg[idx_reg];
                    mem_wr_addr = idx_reg;
                    mem_wr_data = '{seq: rd_data_reg.seq, dest: rd_data_reg.dest,
                                    timer: wr_timer};
                    if (scan_emit)
                    begin
                        emit      = 1'b1;
                        emit_data = '{kind: KIND_RETX, seq: 8'(rd_data_reg.seq),
                                      dest: rd_data_reg.dest, last: 1'b0};
                        n_next    = n_reg + 1'b1;
                    end
                    if (idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + 1'b1;
                        idx_next    = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push_valid      = 1'b1;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            if (pend_valid_reg)
            begin
                push_valid     = 1'b1;
                push_data.last = 1'b0;
            end
            pend_next       = emit_data;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_seq_reg   <= '0;
            next_slot_reg  <= '0;
            last_acked_reg <= '1;
            slot_valid_reg <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_seq_reg   <= next_seq_next;
            next_slot_reg  <= next_slot_next;
            last_acked_reg <= last_acked_next;
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            item_func_reg <= func_t'(func);
            item_seq_reg  <= SEQ_BITS'(seq_number);
            item_dest_reg <= dest_address;
            item_src_reg  <= src_address;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            slot_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= slot_mem[mem_rd_addr];
        end
    end

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind in idle");

    a_hold_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_hold |=> (state_reg == ST_SCAN) && $stable(idx_reg))
        else $error("scan advanced while holding a result");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> out_free)
        else $error("result pushed into a full output register");

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("slot memory read and write hit the same entry");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_RESULTS))
        else $error("tick result count past its cap");

endmodule

`default_nettype wire

@@ rtl/srq_out_stage.sv @@
// Output register of the endpoint: holds one result until the receiver takes it.
// Depends on srq_pkg.
`default_nettype none

module srq_out_stage
    import srq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    input  wire srq_result_t push_data,
    input  wire logic [7:0]  my_address,
    output logic             out_free,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       frame_kind,
    output logic [7:0]       out_seq,
    output logic [7:0]       out_dest,
    output logic [7:0]       out_src,
    output logic             last
);

    logic        out_valid_reg, out_valid_next;
    srq_result_t data_reg;
    logic [7:0]  src_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            data_reg <= push_data;
            src_reg  <= my_address;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = data_reg.kind;
    assign out_seq    = data_reg.seq;
    assign out_dest   = data_reg.dest;
    assign out_src    = src_reg;
    assign last       = data_reg.last;

endmodule

`default_nettype wire

@@ rtl/selective_repeat_arq_endpoint_core.sv @@
// Top level of the selective-repeat ARQ endpoint: configuration registers,
// protocol engine and output register. Depends on srq_pkg, srq_engine, srq_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction: send
//   request, ack, nak, tick or received data frame. Output channel (out_valid /
//   out_stall) carries the frames and acks it causes; last marks the final one.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready.
//   The user writes it only while no event is in flight; the block does not check.
// Timing:
//   Send, data frame and unused codes pass through decode and flush, ack and nak
//   through decode, slot lookup and flush; a result waits in the engine first.
//   A tick reads one slot per cycle from the slot memory while no result is held back.
//   Each event holds the input stalled until its results have left the engine.
// Reset:
//   Slot valid bits clear at once; the slot memory needs no clearing pass.
// Receiver stall:
//   One result waits in the engine and one in the output register; when both
//   are full the tick scan holds at its next result until the receiver takes one.
`default_nettype none

module selective_repeat_arq_endpoint_core
    import srq_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int SEQ_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [7:0]  seq_number,
    input  wire logic [7:0]  dest_address,
    input  wire logic [7:0]  src_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       frame_kind,
    output logic [7:0]       out_seq,
    output logic [7:0]       out_dest,
    output logic [7:0]       out_src,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        push_valid;
    srq_result_t push_data;
    logic        out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MY_ADDR: cfg_next.my_address    = cfg_data[7:0];
                CFG_WINDOW:  cfg_next.window_size   = cfg_data[7:0];
                CFG_TIMEOUT: cfg_next.timeout_ticks = cfg_data[TIMER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{my_address: MY_ADDR_RESET, window_size: WINDOW_RESET,
                         timeout_ticks: TIMEOUT_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srq_engine #(
        .SLOTS    (SLOTS),
        .SEQ_BITS (SEQ_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .seq_number   (seq_number),
        .dest_address (dest_address),
        .src_address  (src_address),
        .cfg          (cfg_reg),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .out_free     (out_free)
    );

    srq_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .my_address (cfg_reg.my_address),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_kind (frame_kind),
        .out_seq    (out_seq),
        .out_dest   (out_dest),
        .out_src    (out_src),
        .last       (last)
    );

endmodule

`default_nettype wire
